>>> design/tccf_pkg.sv
package tccf_pkg;

    // Request codes on the input tuser
    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_SET    = 3'd1,
        REQ_NOTIFY = 3'd2,
        REQ_WAVE   = 3'd3,
        REQ_STOP   = 3'd4,
        REQ_LIMITS = 3'd5,
        REQ_SRESET = 3'd6
    } t_req;

    // Result kinds on the output tuser
    typedef enum logic [1:0] {
        KIND_CTRL   = 2'd0,
        KIND_LIMIT  = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    // Pending strength command per channel
    typedef enum logic [1:0] {
        PM_NONE = 2'd0,
        PM_DEC  = 2'd1,
        PM_INC  = 2'd2,
        PM_ABS  = 2'd3
    } t_pmode;

    // Strength request modes; any other value is an absolute set
    localparam logic [2:0] SM_INC     = 3'd0;
    localparam logic [2:0] SM_DEC     = 3'd1;
    localparam logic [2:0] SM_STEP_UP = 3'd3;
    localparam logic [2:0] SM_STEP_DN = 3'd4;

    // channel field value that selects channel A; all others select B
    localparam logic [1:0] CH_A_SEL = 2'd1;

    localparam int IN_W  = 128;
    localparam int OUT_W = 152;

    // output tdata layout
    localparam int O_HDR_LSB   = 0;
    localparam int O_BYTEA_LSB = 8;
    localparam int O_BYTEB_LSB = 16;
    localparam int O_WAVEA_LSB = 24;
    localparam int O_WAVEB_LSB = 88;

    localparam logic [63:0] SILENT_FRAME = 64'h0A0A_0A0A_0000_0000;
    localparam logic [7:0]  LIMIT_MAX    = 8'd200;
    localparam logic [7:0]  LIMIT_HEADER = 8'd128;
    localparam logic [7:0]  NOTIFY_ACK   = 8'hB1;
    localparam logic [3:0]  SEQ_MAX      = 4'd15;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Decoded command passed from the front end to the executor
    typedef struct packed {
        t_req        op;
        logic        ch;      // 0 channel A, 1 channel B
        t_pmode      pmode;
        logic [7:0]  pval;
        logic [7:0]  nseq;
        logic [7:0]  rep_a;
        logic [7:0]  rep_b;
        logic [63:0] wave;
        logic        first;
        logic [7:0]  lim_a;
        logic [7:0]  lim_b;
    } t_cmd;

endpackage

>>> design/tccf_ram.sv
module tccf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tccf_front.sv
module tccf_front (
    input  logic                        i_valid,
    input  logic                        i_ready,
    input  logic [tccf_pkg::IN_W-1:0]   i_tdata,
    input  logic [2:0]                  i_tuser,
    output logic                        o_push,
    output tccf_pkg::t_cmd              o_cmd
);

    function automatic logic [7:0] clamp_limit(input logic [7:0] v);
        return (v > tccf_pkg::LIMIT_MAX) ? tccf_pkg::LIMIT_MAX : v;
    endfunction

    logic [1:0] chan;
    logic [2:0] smode;
    logic [7:0] sval;
    logic [7:0] ncode;
    logic       keep;

    assign chan  = i_tdata[1:0];
    assign smode = i_tdata[4:2];
    assign sval  = i_tdata[12:5];
    assign ncode = i_tdata[20:13];

    always_comb begin
        o_cmd.op    = tccf_pkg::t_req'(i_tuser);
        o_cmd.ch    = (chan == tccf_pkg::CH_A_SEL) ? 1'b0 : 1'b1;
        o_cmd.nseq  = i_tdata[28:21];
        o_cmd.rep_a = i_tdata[36:29];
        o_cmd.rep_b = i_tdata[44:37];
        o_cmd.wave  = i_tdata[108:45];
        o_cmd.first = i_tdata[109];
        o_cmd.lim_a = clamp_limit(i_tdata[117:110]);
        o_cmd.lim_b = clamp_limit(i_tdata[125:118]);

        unique case (smode) inside
            tccf_pkg::SM_STEP_UP, tccf_pkg::SM_STEP_DN: begin
                o_cmd.pmode = (smode == tccf_pkg::SM_STEP_UP) ? tccf_pkg::PM_INC
                                                              : tccf_pkg::PM_DEC;
                o_cmd.pval  = 8'd1;
            end
            tccf_pkg::SM_INC, tccf_pkg::SM_DEC: begin
                o_cmd.pmode = (smode == tccf_pkg::SM_INC) ? tccf_pkg::PM_INC
                                                          : tccf_pkg::PM_DEC;
                o_cmd.pval  = (sval == 8'd0) ? 8'd1 : sval;
            end
            default: begin
                o_cmd.pmode = tccf_pkg::PM_ABS;
                o_cmd.pval  = clamp_limit(sval);
            end
        endcase

        // unused request codes and foreign notifications never enter the queue
        unique case (i_tuser) inside
            tccf_pkg::REQ_NOTIFY: keep = (ncode == tccf_pkg::NOTIFY_ACK);
            tccf_pkg::REQ_TICK, tccf_pkg::REQ_SET, tccf_pkg::REQ_WAVE,
            tccf_pkg::REQ_STOP, tccf_pkg::REQ_LIMITS, tccf_pkg::REQ_SRESET: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign o_push = i_valid && i_ready && keep;

endmodule

>>> design/tccf_queue.sv
module tccf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tccf_pkg::t_cmd  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output tccf_pkg::t_cmd  o_data,
    input  logic            i_pop
);

    tccf_pkg::t_cmd       r_entry [tccf_pkg::QDEPTH];
    logic [tccf_pkg::QAW-1:0] r_wptr, n_wptr;
    logic [tccf_pkg::QAW-1:0] r_rptr, n_rptr;
    logic [tccf_pkg::QAW:0]   r_count, n_count;

    assign o_ready = (r_count != (tccf_pkg::QAW + 1)'(tccf_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rptr];

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_data;
        end
    end

endmodule

>>> design/tccf_back.sv
module tccf_back #(
    parameter int WAVE_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  tccf_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [tccf_pkg::OUT_W-1:0]  o_tdata,
    output logic [1:0]                  o_tuser
);

    localparam int AW = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;
    localparam int CW = $clog2(WAVE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(WAVE_DEPTH);

    logic [3:0]          r_seq,      n_seq;
    tccf_pkg::t_pmode    r_pmode [2], n_pmode [2];
    logic [7:0]          r_pval  [2], n_pval  [2];
    logic [1:0]          r_wait,     n_wait;
    logic [3:0]          r_ack_seq [2], n_ack_seq [2];
    logic [CW-1:0]       r_wcount [2], n_wcount [2];
    logic [AW-1:0]       r_wpos   [2], n_wpos   [2];

    logic                r_out_valid, n_out_valid;
    tccf_pkg::t_kind     r_kind,     n_kind;
    logic [7:0]          r_header,   n_header;
    logic [7:0]          r_byte_a,   n_byte_a;
    logic [7:0]          r_byte_b,   n_byte_b;
    logic [1:0]          r_silent,   n_silent;

    logic                fire;
    logic [1:0]          send;
    logic [3:0]          seq_inc;
    logic [3:0]          tick_seq;
    logic [CW-1:0]       base_count;
    logic                wave_room;
    logic [1:0]          wave_we;
    logic                ram_re;
    logic [CW-1:0]       pos_inc [2];
    logic [63:0]         ram_q [2];
    logic [63:0]         wave_out [2];

    // an item leaves the queue whenever the output register is free or draining
    assign fire      = i_cmd_valid && (!r_out_valid || i_tready);
    assign o_cmd_pop = fire;

    assign seq_inc    = (r_seq == tccf_pkg::SEQ_MAX) ? 4'd1 : r_seq + 4'd1;
    assign tick_seq   = (|send) ? seq_inc : 4'd0;
    assign base_count = i_cmd.first ? '0 : r_wcount[i_cmd.ch];
    assign wave_room  = (base_count < DEPTH_C);
    assign ram_re     = fire && (i_cmd.op == tccf_pkg::REQ_TICK);

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            send[c]    = (r_pmode[c] != tccf_pkg::PM_NONE) && !r_wait[c];
            pos_inc[c] = CW'(r_wpos[c]) + 1'b1;
            wave_we[c] = fire && (i_cmd.op == tccf_pkg::REQ_WAVE) && (i_cmd.ch == c[0])
                         && wave_room;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_wave
            tccf_ram #(
                .WIDTH (64),
                .DEPTH (WAVE_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (wave_we[g]),
                .i_waddr (base_count[AW-1:0]),
                .i_wdata (i_cmd.wave),
                .i_re    (ram_re),
                .i_raddr (r_wpos[g]),
                .o_rdata (ram_q[g])
            );

            assign wave_out[g] = (r_kind != tccf_pkg::KIND_CTRL) ? 64'd0 :
                                 r_silent[g] ? tccf_pkg::SILENT_FRAME : ram_q[g];
        end
    endgenerate

    always_comb begin
        n_seq       = r_seq;
        n_pmode     = r_pmode;
        n_pval      = r_pval;
        n_wait      = r_wait;
        n_ack_seq   = r_ack_seq;
        n_wcount    = r_wcount;
        n_wpos      = r_wpos;
        n_out_valid = r_out_valid && !i_tready;
        n_kind      = r_kind;
        n_header    = r_header;
        n_byte_a    = r_byte_a;
        n_byte_b    = r_byte_b;
        n_silent    = r_silent;

        if (fire) begin
            unique case (i_cmd.op)
                tccf_pkg::REQ_TICK: begin
                    n_out_valid = 1'b1;
                    n_kind      = tccf_pkg::KIND_CTRL;
                    n_header    = {tick_seq,
                                   send[0] ? r_pmode[0] : tccf_pkg::PM_NONE,
                                   send[1] ? r_pmode[1] : tccf_pkg::PM_NONE};
                    n_byte_a    = send[0] ? r_pval[0] : 8'd0;
                    n_byte_b    = send[1] ? r_pval[1] : 8'd0;
                    if (|send) begin
                        n_seq = seq_inc;
                    end
                    for (int c = 0; c < 2; c++) begin
                        n_silent[c] = (r_wcount[c] == '0);
                        if (send[c]) begin
                            n_wait[c]    = 1'b1;
                            n_ack_seq[c] = seq_inc;
                            n_pmode[c]   = tccf_pkg::PM_NONE;
                        end
                        if (r_wcount[c] != '0) begin
                            n_wpos[c] = (pos_inc[c] == r_wcount[c]) ? '0 : pos_inc[c][AW-1:0];
                        end
                    end
                end
                tccf_pkg::REQ_SET: begin
                    n_pmode[i_cmd.ch] = i_cmd.pmode;
                    n_pval[i_cmd.ch]  = i_cmd.pval;
                end
                tccf_pkg::REQ_NOTIFY: begin
                    // full 8-bit compare against the 4-bit stored sequence
                    for (int c = 0; c < 2; c++) begin
                        if (r_wait[c] && (i_cmd.nseq == {4'd0, r_ack_seq[c]})) begin
                            n_wait[c] = 1'b0;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_kind      = tccf_pkg::KIND_REPORT;
                    n_header    = i_cmd.nseq;
                    n_byte_a    = i_cmd.rep_a;
                    n_byte_b    = i_cmd.rep_b;
                end
                tccf_pkg::REQ_WAVE: begin
                    if (i_cmd.first) begin
                        n_wcount[i_cmd.ch] = '0;
                        n_wpos[i_cmd.ch]   = '0;
                    end
                    if (wave_room) begin
                        n_wcount[i_cmd.ch] = base_count + 1'b1;
                    end
                end
                tccf_pkg::REQ_STOP: begin
                    n_wcount[i_cmd.ch] = '0;
                    n_wpos[i_cmd.ch]   = '0;
                end
                tccf_pkg::REQ_LIMITS: begin
                    n_out_valid = 1'b1;
                    n_kind      = tccf_pkg::KIND_LIMIT;
                    n_header    = tccf_pkg::LIMIT_HEADER;
                    n_byte_a    = i_cmd.lim_a;
                    n_byte_b    = i_cmd.lim_b;
                end
                tccf_pkg::REQ_SRESET: begin
                    for (int c = 0; c < 2; c++) begin
                        n_wcount[c] = '0;
                        n_wpos[c]   = '0;
                        n_pmode[c]  = tccf_pkg::PM_NONE;
                    end
                    n_wait = 2'b00;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= 4'd0;
            r_wait      <= 2'b00;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_pmode[c]   <= tccf_pkg::PM_NONE;
                r_pval[c]    <= 8'd0;
                r_ack_seq[c] <= 4'd0;
                r_wcount[c]  <= '0;
                r_wpos[c]    <= '0;
            end
        end else begin
            r_seq       <= n_seq;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            r_pmode     <= n_pmode;
            r_pval      <= n_pval;
            r_ack_seq   <= n_ack_seq;
            r_wcount    <= n_wcount;
            r_wpos      <= n_wpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_header <= n_header;
        r_byte_a <= n_byte_a;
        r_byte_b <= n_byte_b;
        r_silent <= n_silent;
    end

    assign o_tvalid = r_out_valid;
    assign o_tuser  = r_kind;
    assign o_tdata  = {wave_out[1], wave_out[0], r_byte_b, r_byte_a, r_header};

endmodule

>>> design/two_channel_command_framer_unit.sv
// Two-channel command framer. Requests arrive on s_axis with the request code in
// tuser; frames leave on m_axis with the frame kind in tuser. The block sustains
// one transaction per clock in each direction while m_axis is not stalled:
// a front decoder drops unused codes and foreign notifications, a two-entry
// command queue decouples input from the executor, and the executor updates
// channel state and loads the output register in the same cycle. A result
// passes through the queue register and then the output register, which loads
// together with the registered read of the per-channel wave store RAM.
// s_axis_tready drops only while the queue holds two commands, which happens
// when m_axis is stalled.
module two_channel_command_framer_unit #(
    parameter int WAVE_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] channel, [4:2] strength_mode, [12:5] strength_value,
    // [20:13] notify_code, [28:21] notify_seq, [36:29] report_a,
    // [44:37] report_b, [108:45] wave_frame, [109] wave_first,
    // [117:110] limit_a, [125:118] limit_b, [127:126] zero
    input  logic [tccf_pkg::IN_W-1:0]   s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] header_byte, [15:8] byte_a, [23:16] byte_b,
    // [87:24] wave_a, [151:88] wave_b
    output logic [tccf_pkg::OUT_W-1:0]  m_axis_tdata,
    // [1:0] frame_kind
    output logic [1:0]                  m_axis_tuser
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    tccf_pkg::t_cmd front_cmd;
    tccf_pkg::t_cmd q_cmd;

    assign s_axis_tready = q_ready;

    tccf_front u_front (
        .i_valid (s_axis_tvalid),
        .i_ready (q_ready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    tccf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (pop)
    );

    tccf_back #(
        .WAVE_DEPTH (WAVE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule

>>> design/tccf_checker.sv
module tccf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tvalid,
    input  logic                        i_tready,
    input  logic [tccf_pkg::OUT_W-1:0]  i_tdata,
    input  logic [1:0]                  i_tuser
);

    logic [7:0]  hdr;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [63:0] wave_a;
    logic [63:0] wave_b;

    assign hdr    = i_tdata[tccf_pkg::O_HDR_LSB +: 8];
    assign byte_a = i_tdata[tccf_pkg::O_BYTEA_LSB +: 8];
    assign byte_b = i_tdata[tccf_pkg::O_BYTEB_LSB +: 8];
    assign wave_a = i_tdata[tccf_pkg::O_WAVEA_LSB +: 64];
    assign wave_b = i_tdata[tccf_pkg::O_WAVEB_LSB +: 64];

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && !i_tready |=> i_tvalid && $stable(i_tdata) && $stable(i_tuser))
        else $error("output transaction changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid |-> (i_tuser == tccf_pkg::KIND_CTRL) || (i_tuser == tccf_pkg::KIND_LIMIT)
                     || (i_tuser == tccf_pkg::KIND_REPORT))
        else $error("undefined frame kind");

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && (i_tuser == tccf_pkg::KIND_LIMIT) |->
            (hdr == tccf_pkg::LIMIT_HEADER) && (byte_a <= tccf_pkg::LIMIT_MAX)
            && (byte_b <= tccf_pkg::LIMIT_MAX))
        else $error("limit frame malformed");

    a_no_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && (i_tuser != tccf_pkg::KIND_CTRL) |-> (wave_a == 64'd0) && (wave_b == 64'd0))
        else $error("wave data in non-control frame");

    // no command in a control frame means sequence, modes and values all zero
    a_idle_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && (i_tuser == tccf_pkg::KIND_CTRL) && (hdr[7:4] == 4'd0) |->
            (hdr[3:0] == 4'd0) && (byte_a == 8'd0) && (byte_b == 8'd0))
        else $error("control frame carries command without sequence");

endmodule

bind two_channel_command_framer_unit tccf_checker u_tccf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (m_axis_tvalid),
    .i_tready (m_axis_tready),
    .i_tdata  (m_axis_tdata),
    .i_tuser  (m_axis_tuser)
);

>>> tb/sv/two_channel_command_framer_unit_tb.sv
localparam int RING_DEPTH = 8;
localparam logic [2:0] REQ_UNUSED = 3'd7;
localparam logic [2:0] SM_OTHER   = 3'd7;

// s_axis_tdata layout, MSB first
typedef struct packed {
    logic [1:0]  pad;
    logic [7:0]  lim_b;
    logic [7:0]  lim_a;
    logic        wfirst;
    logic [63:0] wave;
    logic [7:0]  rep_b;
    logic [7:0]  rep_a;
    logic [7:0]  nseq;
    logic [7:0]  ncode;
    logic [7:0]  sval;
    logic [2:0]  smode;
    logic [1:0]  chan;
} t_req_fields;

// {m_axis_tuser, m_axis_tdata}
typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] wave_b;
    logic [63:0] wave_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_a;
    logic [7:0]  hdr;
} t_frame;

// Tracks channel state and the frames the framer owes us.
class frame_tracker;
    logic [3:0]       seq_cnt;
    tccf_pkg::t_pmode pend_mode [2];
    logic [7:0]       pend_val [2];
    bit               acking [2];
    logic [3:0]       ack_seq [2];
    logic [63:0]      ring [2][RING_DEPTH];
    int               ring_cnt [2];
    int               ring_pos [2];
    t_frame           expected_frames [$];
    int               errors;

    function new();
        seq_cnt = '0;
        errors = 0;
        for (int c = 0; c < 2; c++) begin
            pend_mode[c] = tccf_pkg::PM_NONE;
            pend_val[c] = '0;
            acking[c] = 1'b0;
            ack_seq[c] = '0;
            ring_cnt[c] = 0;
            ring_pos[c] = 0;
            for (int j = 0; j < RING_DEPTH; j++)
                ring[c][j] = '0;
        end
    endfunction

    function logic [7:0] clamp_limit(logic [7:0] v);
        return (v > tccf_pkg::LIMIT_MAX) ? tccf_pkg::LIMIT_MAX : v;
    endfunction

    function logic [63:0] ring_word(int c);
        if (ring_cnt[c] == 0 || ring_pos[c] >= RING_DEPTH)
            return tccf_pkg::SILENT_FRAME;
        return ring[c][ring_pos[c]];
    endfunction

    function void take_request(logic [2:0] code, t_req_fields f);
        int         ch;
        bit         send [2];
        logic [3:0] seq;
        t_frame     want;
        ch = (f.chan == tccf_pkg::CH_A_SEL) ? 0 : 1;
        want = '0;
        case (code)
            tccf_pkg::REQ_TICK: begin
                seq = '0;
                for (int c = 0; c < 2; c++)
                    send[c] = (pend_mode[c] != tccf_pkg::PM_NONE) && !acking[c];
                if (send[0] || send[1]) begin
                    seq = (seq_cnt == tccf_pkg::SEQ_MAX) ? 4'd1 : seq_cnt + 4'd1;
                    seq_cnt = seq;
                end
                want.kind = tccf_pkg::KIND_CTRL;
                want.hdr = {seq, send[0] ? pend_mode[0] : tccf_pkg::PM_NONE,
                            send[1] ? pend_mode[1] : tccf_pkg::PM_NONE};
                want.byte_a = send[0] ? pend_val[0] : 8'd0;
                want.byte_b = send[1] ? pend_val[1] : 8'd0;
                want.wave_a = ring_word(0);
                want.wave_b = ring_word(1);
                for (int c = 0; c < 2; c++) begin
                    if (send[c]) begin
                        acking[c] = 1'b1;
                        ack_seq[c] = seq;
                        pend_mode[c] = tccf_pkg::PM_NONE;
                    end
                    if (ring_cnt[c] != 0)
                        ring_pos[c] = (ring_pos[c] + 1) % ring_cnt[c];
                end
                expected_frames.push_back(want);
            end
            tccf_pkg::REQ_SET: begin
                case (f.smode)
                    tccf_pkg::SM_STEP_UP, tccf_pkg::SM_STEP_DN: begin
                        pend_mode[ch] = (f.smode == tccf_pkg::SM_STEP_UP) ? tccf_pkg::PM_INC
                                                                          : tccf_pkg::PM_DEC;
                        pend_val[ch] = 8'd1;
                    end
                    tccf_pkg::SM_INC, tccf_pkg::SM_DEC: begin
                        pend_mode[ch] = (f.smode == tccf_pkg::SM_INC) ? tccf_pkg::PM_INC
                                                                      : tccf_pkg::PM_DEC;
                        pend_val[ch] = (f.sval == 8'd0) ? 8'd1 : f.sval;
                    end
                    default: begin
                        pend_mode[ch] = tccf_pkg::PM_ABS;
                        pend_val[ch] = clamp_limit(f.sval);
                    end
                endcase
            end
            tccf_pkg::REQ_NOTIFY: begin
                if (f.ncode == tccf_pkg::NOTIFY_ACK) begin
                    // full byte compare: upper nibble set never matches
                    for (int c = 0; c < 2; c++)
                        if (acking[c] && f.nseq == {4'd0, ack_seq[c]})
                            acking[c] = 1'b0;
                    want.kind = tccf_pkg::KIND_REPORT;
                    want.hdr = f.nseq;
                    want.byte_a = f.rep_a;
                    want.byte_b = f.rep_b;
                    expected_frames.push_back(want);
                end
            end
            tccf_pkg::REQ_WAVE: begin
                if (f.wfirst) begin
                    ring_cnt[ch] = 0;
                    ring_pos[ch] = 0;
                end
                if (ring_cnt[ch] < RING_DEPTH) begin
                    ring[ch][ring_cnt[ch]] = f.wave;
                    ring_cnt[ch]++;
                end
            end
            tccf_pkg::REQ_STOP: begin
                ring_cnt[ch] = 0;
                ring_pos[ch] = 0;
            end
            tccf_pkg::REQ_LIMITS: begin
                want.kind = tccf_pkg::KIND_LIMIT;
                want.hdr = tccf_pkg::LIMIT_HEADER;
                want.byte_a = clamp_limit(f.lim_a);
                want.byte_b = clamp_limit(f.lim_b);
                expected_frames.push_back(want);
            end
            tccf_pkg::REQ_SRESET: begin
                for (int c = 0; c < 2; c++) begin
                    ring_cnt[c] = 0;
                    ring_pos[c] = 0;
                    pend_mode[c] = tccf_pkg::PM_NONE;
                    acking[c] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function void field_check(string nm, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", nm, want, got);
        end
    endfunction

    function void check_frame(t_frame got);
        t_frame want;
        if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected frame: kind %0d hdr %h", got.kind, got.hdr);
            return;
        end
        want = expected_frames.pop_front();
        field_check("frame_kind", 64'(want.kind), 64'(got.kind));
        field_check("header_byte", 64'(want.hdr), 64'(got.hdr));
        field_check("byte_a", 64'(want.byte_a), 64'(got.byte_a));
        field_check("byte_b", 64'(want.byte_b), 64'(got.byte_b));
        field_check("wave_a", want.wave_a, got.wave_a);
        field_check("wave_b", want.wave_b, got.wave_b);
    endfunction
endclass

module two_channel_command_framer_unit_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 64;
    localparam int RAND_ITEMS   = 1090;
    localparam int SETTLE       = 4;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [tccf_pkg::IN_W-1:0]    s_axis_tdata;
    logic [2:0]                   s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [tccf_pkg::OUT_W-1:0]   m_axis_tdata;
    logic [1:0]                   m_axis_tuser;

    frame_tracker sb;
    bit           hold_req;
    int           cycles;

    two_channel_command_framer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("two_channel_command_framer_unit_tb: FAIL");
            $finish;
        end
    end

    // input transaction is noted before the output is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_request(s_axis_tuser, t_req_fields'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_frame(t_frame'({m_axis_tuser, m_axis_tdata}));
        end
    end

    // receiver: stretches of varying stall density, plus one long hold-off
    initial begin
        int stall_pct;
        int stretch;
        bit hold_done;
        stall_pct = 0;
        stretch = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stretch == 0) begin
                stretch = $urandom_range(8, 60);
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stretch--;
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_req(logic [2:0] code, t_req_fields f);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= f;
        s_axis_tuser <= code;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(posedge i_clk);
        // requests without a frame may still be in flight
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic roll_request(output logic [2:0] code, output t_req_fields f);
        int r;
        f = t_req_fields'({$urandom, $urandom, $urandom, $urandom});
        f.pad = '0;
        f.wfirst = ($urandom_range(99) < 15);
        if ($urandom_range(99) < 88)
            f.ncode = tccf_pkg::NOTIFY_ACK;
        r = $urandom_range(9);
        if (r < 5)
            f.nseq = {4'd0, sb.ack_seq[$urandom_range(1)]};
        else if (r < 7)
            f.nseq = 8'($urandom_range(15));
        r = $urandom_range(99);
        if (r < 30)
            code = tccf_pkg::REQ_TICK;
        else if (r < 48)
            code = tccf_pkg::REQ_SET;
        else if (r < 60)
            code = tccf_pkg::REQ_NOTIFY;
        else if (r < 78)
            code = tccf_pkg::REQ_WAVE;
        else if (r < 81)
            code = tccf_pkg::REQ_STOP;
        else if (r < 88)
            code = tccf_pkg::REQ_LIMITS;
        else if (r < 91)
            code = tccf_pkg::REQ_SRESET;
        else if (r < 93)
            code = REQ_UNUSED;
        else
            code = tccf_pkg::REQ_TICK;
    endtask

    initial begin
        t_req_fields f;
        logic [2:0]  code;
        int          sent;
        int          burst;
        int          gap;
        bit          held;
        bit          paused;
        sb = new();
        hold_req = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tick with nothing pending and empty rings
        f = '0;
        send_req(tccf_pkg::REQ_TICK, f);
        f.lim_a = 8'd0;
        f.lim_b = 8'd255;
        send_req(tccf_pkg::REQ_LIMITS, f);
        f = '0;
        f.chan = tccf_pkg::CH_A_SEL;
        send_req(tccf_pkg::REQ_SET, f);
        f.chan = 2'd2;
        f.smode = SM_OTHER;
        f.sval = 8'd255;
        send_req(tccf_pkg::REQ_SET, f);
        f = '0;
        send_req(tccf_pkg::REQ_TICK, f);
        send_req(tccf_pkg::REQ_TICK, f);
        f.smode = tccf_pkg::SM_STEP_UP;
        send_req(tccf_pkg::REQ_SET, f);
        f = '0;
        f.ncode = 8'h55;
        f.nseq = 8'd1;
        send_req(tccf_pkg::REQ_NOTIFY, f);
        f.ncode = tccf_pkg::NOTIFY_ACK;
        f.nseq = 8'h11;
        f.rep_a = 8'd255;
        send_req(tccf_pkg::REQ_NOTIFY, f);
        f.nseq = 8'd1;
        f.rep_a = 8'd0;
        f.rep_b = 8'd255;
        send_req(tccf_pkg::REQ_NOTIFY, f);
        f = '0;
        send_req(tccf_pkg::REQ_TICK, f);
        f.chan = 2'd3;
        send_req(REQ_UNUSED, f);
        // fill channel A ring past its depth; last entry is dropped
        f = '0;
        f.chan = tccf_pkg::CH_A_SEL;
        for (int k = 0; k < RING_DEPTH + 1; k++) begin
            f.wfirst = (k == 0);
            f.wave = (k == 0) ? '1 : {$urandom, $urandom};
            send_req(tccf_pkg::REQ_WAVE, f);
        end
        f = '0;
        send_req(tccf_pkg::REQ_TICK, f);
        f.chan = tccf_pkg::CH_A_SEL;
        send_req(tccf_pkg::REQ_STOP, f);
        send_req(tccf_pkg::REQ_SRESET, f);
        f = '0;
        send_req(tccf_pkg::REQ_TICK, f);
        drain();

        sent = 0;
        held = 1'b0;
        paused = 1'b0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                roll_request(code, f);
                send_req(code, f);
                if (code != REQ_UNUSED &&
                    !(code == tccf_pkg::REQ_NOTIFY && f.ncode != tccf_pkg::NOTIFY_ACK))
                    sent++;
            end
            if (!held && sent >= 400) begin
                // stall the output and keep pushing ticks until input backs up
                held = 1'b1;
                hold_req = 1'b1;
                repeat (30) begin
                    f = t_req_fields'({$urandom, $urandom, $urandom, $urandom});
                    f.pad = '0;
                    send_req(tccf_pkg::REQ_TICK, f);
                    sent++;
                end
            end
            if (!paused && sent >= 800) begin
                paused = 1'b1;
                drain();
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_frames.size() == 0)
            $display("two_channel_command_framer_unit_tb: PASS");
        else
            $display("two_channel_command_framer_unit_tb: FAIL");
        $finish;
    end

endmodule
